FILE: design/quadratic_root_solver_defines.svh
// Assertion macros used by the checker file
`ifndef QUADRATIC_ROOT_SOLVER_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_DEFINES_SVH

// Implication checked at every clock edge outside reset
`define QRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qrs check failed");

// Invariant checked at every clock edge outside reset
`define QRS_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("qrs check failed");

`endif

FILE: design/qrs_pkg.sv
package qrs_pkg;

    localparam int COEF_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_A_ZERO = 2'd1,
        ST_D_ZERO = 2'd2,
        ST_D_NEG  = 2'd3
    } status_t;

endpackage

FILE: design/quadratic_root_solver.sv
// Pipeline: capture register, COEF_WIDTH+FRAC_BITS+1 square root stages, COEF_WIDTH+FRAC_BITS+2
// divider stages and four more: products, discriminant, numerators and the output register.
// Throughput: one coefficient set per cycle while busy is low; the results are never stalled.
// busy is set by reset and clears at the clock edge after reset is released.
// Reset (rst_n low, asynchronous) clears all valid bits; data registers keep no reset.
module quadratic_root_solver #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COEF_WIDTH-1:0]        coef_a,
    input  logic signed [COEF_WIDTH-1:0]        coef_b,
    input  logic signed [COEF_WIDTH-1:0]        coef_c,
    output logic                                done,
    output logic        [1:0]                   status,
    output logic signed [COEF_WIDTH+FRAC_BITS:0] root_plus,
    output logic signed [COEF_WIDTH+FRAC_BITS:0] root_minus
);
    import qrs_pkg::*;

    localparam int W   = COEF_WIDTH;
    localparam int F   = FRAC_BITS;
    localparam int DW  = 2*W + 3;      // signed discriminant
    localparam int RW  = W + 1 + F;    // square root bits
    localparam int XW  = 2*RW;         // scaled radicand
    localparam int NW  = W + F + 2;    // numerator magnitude
    localparam int DNW = W + 1;        // denominator magnitude
    localparam int RTW = W + F + 1;    // root width

    logic busy_reg;
    logic accept;

    // input stage
    logic                v0_reg;
    logic signed [W-1:0] a0_reg, b0_reg, c0_reg;
    // product stage
    logic                  v1_reg;
    logic signed [2*W-1:0] bb1_reg, ac1_reg;
    logic signed [W-1:0]   a1_reg, b1_reg;
    // discriminant
    logic signed [DW-1:0]  disc;
    status_t               st_next;

    // square root stages
    logic          sq_v_reg    [0:RW];
    status_t       sq_st_reg   [0:RW];
    logic [XW-1:0] sq_x_reg    [0:RW];
    logic [RW+1:0] sq_rem_reg  [0:RW];
    logic [RW-1:0] sq_root_reg [0:RW];
    logic [W-1:0]  sq_a_reg    [0:RW];
    logic [W-1:0]  sq_b_reg    [0:RW];

    // divider stages
    logic           dv_v_reg   [0:NW];
    status_t        dv_st_reg  [0:NW];
    logic [NW-1:0]  dv_np_reg  [0:NW];
    logic [NW-1:0]  dv_nm_reg  [0:NW];
    logic [DNW-1:0] dv_rp_reg  [0:NW];
    logic [DNW-1:0] dv_rm_reg  [0:NW];
    logic [NW-1:0]  dv_qp_reg  [0:NW];
    logic [NW-1:0]  dv_qm_reg  [0:NW];
    logic [DNW-1:0] dv_den_reg [0:NW];
    logic           dv_sp_reg  [0:NW];
    logic           dv_sm_reg  [0:NW];

    // numerator stage signals
    logic signed [NW:0]  bx, nb, rx, plus_s, minus_s;
    logic signed [W:0]   ax;
    logic signed [W+1:0] den_s;

    // output
    logic                  done_reg;
    status_t               status_reg;
    logic signed [RTW-1:0] rp_reg, rm_reg;
    logic signed [NW:0]    qp_s, qm_s;

    assign accept = start && !busy_reg;

    // busy only around reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
        end
    end

    // valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else
        begin
            v0_reg      <= accept;
            v1_reg      <= v0_reg;
            sq_v_reg[0] <= v1_reg;
        end
    end

    // input capture and products
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a0_reg <= coef_a;
            b0_reg <= coef_b;
            c0_reg <= coef_c;
        end
        bb1_reg <= b0_reg * b0_reg;
        ac1_reg <= a0_reg * c0_reg;
        a1_reg  <= a0_reg;
        b1_reg  <= b0_reg;
    end

    // discriminant and status
    always_comb
    begin
        disc = DW'(bb1_reg) - (DW'(ac1_reg) <<< 2);
        if (a1_reg == '0)
        begin
            st_next = ST_A_ZERO;
        end
        else if (disc[DW-1])
        begin
            st_next = ST_D_NEG;
        end
        else if (disc == '0)
        begin
            st_next = ST_D_ZERO;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_st_reg[0]   <= st_next;
        sq_x_reg[0]    <= {1'b0, disc[2*W:0], {(2*F){1'b0}}};
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        sq_a_reg[0]    <= a1_reg;
        sq_b_reg[0]    <= b1_reg;
    end

    // one root digit per stage
    for (genvar k = 1; k <= RW; k++)
    begin : g_sqrt
        logic [RW+1:0] remc, trial;
        logic          fits;

        always_comb
        begin
            remc  = {sq_rem_reg[k-1][RW-1:0], sq_x_reg[k-1][2*(RW-k)+1 -: 2]};
            trial = {sq_root_reg[k-1], 2'b01};
            fits  = (remc >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[k] <= 1'b0;
            end
            else
            begin
                sq_v_reg[k] <= sq_v_reg[k-1];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_st_reg[k]   <= sq_st_reg[k-1];
            sq_x_reg[k]    <= sq_x_reg[k-1];
            sq_rem_reg[k]  <= fits ? (remc - trial) : remc;
            sq_root_reg[k] <= {sq_root_reg[k-1][RW-2:0], fits};
            sq_a_reg[k]    <= sq_a_reg[k-1];
            sq_b_reg[k]    <= sq_b_reg[k-1];
        end
    end

    // numerators and denominator magnitudes
    always_comb
    begin
        bx      = (NW+1)'($signed(sq_b_reg[RW]));
        nb      = -(bx <<< F);
        rx      = $signed({{(NW+1-RW){1'b0}}, sq_root_reg[RW]});
        plus_s  = nb + rx;
        minus_s = nb - rx;
        ax      = (W+1)'($signed(sq_a_reg[RW]));
        den_s   = (W+2)'(ax) <<< 1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else
        begin
            dv_v_reg[0] <= sq_v_reg[RW];
        end
    end

    always_ff @(posedge clk)
    begin
        dv_st_reg[0]  <= sq_st_reg[RW];
        dv_np_reg[0]  <= plus_s[NW]  ? NW'(-plus_s)  : plus_s[NW-1:0];
        dv_nm_reg[0]  <= minus_s[NW] ? NW'(-minus_s) : minus_s[NW-1:0];
        dv_sp_reg[0]  <= plus_s[NW]  ^ ax[W];
        dv_sm_reg[0]  <= minus_s[NW] ^ ax[W];
        dv_den_reg[0] <= den_s[W+1] ? DNW'(-den_s) : den_s[DNW-1:0];
        dv_rp_reg[0]  <= '0;
        dv_rm_reg[0]  <= '0;
        dv_qp_reg[0]  <= '0;
        dv_qm_reg[0]  <= '0;
    end

    // one quotient bit per stage, both roots side by side
    for (genvar j = 1; j <= NW; j++)
    begin : g_div
        logic [DNW:0] rcp, rcm, dn;
        logic         gp, gm;

        always_comb
        begin
            rcp = {dv_rp_reg[j-1], dv_np_reg[j-1][NW-j]};
            rcm = {dv_rm_reg[j-1], dv_nm_reg[j-1][NW-j]};
            dn  = {1'b0, dv_den_reg[j-1]};
            gp  = (rcp >= dn);
            gm  = (rcm >= dn);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else
            begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            dv_st_reg[j]  <= dv_st_reg[j-1];
            dv_np_reg[j]  <= dv_np_reg[j-1];
            dv_nm_reg[j]  <= dv_nm_reg[j-1];
            dv_sp_reg[j]  <= dv_sp_reg[j-1];
            dv_sm_reg[j]  <= dv_sm_reg[j-1];
            dv_den_reg[j] <= dv_den_reg[j-1];
            dv_rp_reg[j]  <= gp ? DNW'(rcp - dn) : rcp[DNW-1:0];
            dv_rm_reg[j]  <= gm ? DNW'(rcm - dn) : rcm[DNW-1:0];
            dv_qp_reg[j]  <= {dv_qp_reg[j-1][NW-2:0], gp};
            dv_qm_reg[j]  <= {dv_qm_reg[j-1][NW-2:0], gm};
        end
    end

    // signed quotients, truncated toward zero
    always_comb
    begin
        qp_s = dv_sp_reg[NW] ? -$signed({1'b0, dv_qp_reg[NW]}) : $signed({1'b0, dv_qp_reg[NW]});
        qm_s = dv_sm_reg[NW] ? -$signed({1'b0, dv_qm_reg[NW]}) : $signed({1'b0, dv_qm_reg[NW]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_v_reg[NW];
        end
    end

    // result register, roots zero on any error
    always_ff @(posedge clk)
    begin
        status_reg <= dv_st_reg[NW];
        if (dv_st_reg[NW] == ST_OK)
        begin
            rp_reg <= qp_s[RTW-1:0];
            rm_reg <= qm_s[RTW-1:0];
        end
        else
        begin
            rp_reg <= '0;
            rm_reg <= '0;
        end
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign root_plus  = rp_reg;
    assign root_minus = rm_reg;

endmodule

FILE: design/qrs_checker.sv
`include "quadratic_root_solver_defines.svh"

module qrs_checker #(
    parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic signed [COEF_WIDTH-1:0]        coef_a,
    input logic                                done,
    input logic        [1:0]                   status,
    input logic signed [COEF_WIDTH+FRAC_BITS:0] root_plus,
    input logic signed [COEF_WIDTH+FRAC_BITS:0] root_minus
);
    import qrs_pkg::*;

    // edges from a start transfer to the edge that takes its result
    localparam int LAT = 2*COEF_WIDTH + 2*FRAC_BITS + 8;

    // every transfer gives exactly one result at fixed latency
    `QRS_ASSERT_ALWAYS(a_latency, clk, rst_n, done == $past(start && !busy, LAT))
    // error results carry zero roots
    `QRS_ASSERT_IMP(a_err_zero, clk, rst_n, done && (status != ST_OK), (root_plus == '0) && (root_minus == '0))
    // zero leading coefficient is reported as such
    `QRS_ASSERT_IMP(a_a_zero, clk, rst_n, done && ($past(coef_a, LAT) == '0), status == ST_A_ZERO)

endmodule

bind quadratic_root_solver qrs_checker #(
    .COEF_WIDTH(COEF_WIDTH),
    .FRAC_BITS (FRAC_BITS)
) u_qrs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .coef_a    (coef_a),
    .done      (done),
    .status    (status),
    .root_plus (root_plus),
    .root_minus(root_minus)
);

FILE: test/quadratic_root_solver_test.sv
`timescale 1ns / 1ps

module quadratic_root_solver_test;
    import qrs_pkg::*;

    localparam int CW = 16;
    localparam int FB = 16;
    localparam int RW = CW + FB + 1;
    localparam int LATENCY = 71;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_SETS = 530;

    typedef struct {
        status_t              st;
        logic signed [RW-1:0] rp;
        logic signed [RW-1:0] rm;
    } roots_t;

    typedef struct {
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        bit                   typed;
        roots_t               res;
    } coef_row_t;

    logic                 clk = 0;
    logic                 rst_n = 0;
    logic                 start = 0;
    logic                 busy;
    logic signed [CW-1:0] coef_a = 0;
    logic signed [CW-1:0] coef_b = 0;
    logic signed [CW-1:0] coef_c = 0;
    logic                 done;
    logic [1:0]           status;
    logic signed [RW-1:0] root_plus;
    logic signed [RW-1:0] root_minus;

    roots_t    pending_roots[$];
    coef_row_t directed[$];
    int        mismatches = 0;
    int        checked = 0;
    int        cycles = 0;
    int        st_seen[4];

    quadratic_root_solver dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .done(done), .status(status), .root_plus(root_plus), .root_minus(root_minus)
    );

    always #5 clk = ~clk;

    // floor(sqrt(v)) of the scaled discriminant, two bits per step
    function automatic logic [33:0] scaled_isqrt(input logic [65:0] v);
        logic [33:0] r;
        logic [39:0] rem;
        logic [39:0] trial;
        r = 0;
        rem = 0;
        for (int p = 32; p >= 0; p--)
        begin
            rem = (rem << 2) | v[2*p+1 -: 2];
            trial = ({6'b0, r} << 2) | 40'd1;
            if (rem >= trial)
            begin
                rem = rem - trial;
                r = (r << 1) | 34'd1;
            end
            else
                r = r << 1;
        end
        return r;
    endfunction

    function automatic roots_t solve_roots(input logic signed [CW-1:0] a,
                                           input logic signed [CW-1:0] b,
                                           input logic signed [CW-1:0] c);
        roots_t res;
        longint disc;
        longint sq;
        longint nb;
        longint den;
        longint qp;
        longint qm;
        res.st = ST_OK;
        res.rp = 0;
        res.rm = 0;
        disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        if (a == 0)
            res.st = ST_A_ZERO;
        else if (disc < 0)
            res.st = ST_D_NEG;
        else if (disc == 0)
            res.st = ST_D_ZERO;
        else
        begin
            sq = longint'(scaled_isqrt({disc[33:0], 32'b0}));
            nb = -longint'(b) * (longint'(1) << FB);
            den = 2 * longint'(a);
            qp = (nb + sq) / den;
            qm = (nb - sq) / den;
            res.rp = qp[RW-1:0];
            res.rm = qm[RW-1:0];
        end
        return res;
    endfunction

    function automatic void add_row(input int a, input int b, input int c,
                                    input bit typed, input status_t st,
                                    input longint rp, input longint rm);
        coef_row_t row;
        row.a = CW'(a);
        row.b = CW'(b);
        row.c = CW'(c);
        row.typed = typed;
        row.res.st = st;
        row.res.rp = rp[RW-1:0];
        row.res.rm = rm[RW-1:0];
        directed.push_back(row);
    endfunction

    // gap before a transfer: mostly none, some short, a few long
    task automatic sender_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick >= 60 && pick < 92)
        begin
            start <= 0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        else if (pick >= 92)
        begin
            start <= 0;
            repeat ($urandom_range(20, 120)) @(posedge clk);
        end
    endtask

    // one coefficient transfer; start stays high if the next one follows at once
    task automatic send_coefs(input logic signed [CW-1:0] a,
                              input logic signed [CW-1:0] b,
                              input logic signed [CW-1:0] c,
                              input bit typed, input roots_t res);
        sender_gap();
        start <= 1;
        coef_a <= a;
        coef_b <= b;
        coef_c <= c;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_roots.push_back(typed ? res : solve_roots(a, b, c));
    endtask

    task automatic send_random();
        int kind;
        int k;
        int r1;
        int r2;
        logic signed [CW-1:0] a;
        logic signed [CW-1:0] b;
        logic signed [CW-1:0] c;
        roots_t none;
        none.st = ST_OK;
        none.rp = 0;
        none.rm = 0;
        kind = $urandom_range(0, 9);
        a = CW'($urandom);
        b = CW'($urandom);
        c = CW'($urandom);
        if (kind < 3)
        begin
            // factored form: a(x - r1)(x - r2), real roots
            k = $signed($urandom_range(0, 14)) - 7;
            if (k == 0)
                k = 1;
            r1 = $signed($urandom_range(0, 40)) - 20;
            r2 = $signed($urandom_range(0, 40)) - 20;
            a = CW'(k);
            b = CW'(-k * (r1 + r2));
            c = CW'(k * r1 * r2);
        end
        else if (kind < 5)
        begin
            // small coefficients, any sign
            a = CW'($signed($urandom_range(0, 64)) - 32);
            b = CW'($signed($urandom_range(0, 256)) - 128);
            c = CW'($signed($urandom_range(0, 256)) - 128);
        end
        else if (kind == 5)
        begin
            // repeated root: k(x - m)^2
            k = $signed($urandom_range(0, 20)) - 10;
            if (k == 0)
                k = -1;
            r1 = $signed($urandom_range(0, 30)) - 15;
            a = CW'(k);
            b = CW'(-2 * k * r1);
            c = CW'(k * r1 * r1);
        end
        else if (kind == 6)
        begin
            // opposite signs of a and c: always positive discriminant
            a = CW'($urandom_range(1, 32767));
            c = CW'(-$signed($urandom_range(0, 32766)) - 1);
            if ($urandom_range(0, 1))
            begin
                a = -a;
                c = -c;
            end
        end
        else if (kind == 7)
            a = 0;
        send_coefs(a, b, c, 0, none);
    endtask

    // result checker
    always @(posedge clk)
    begin
        roots_t want;
        if (rst_n && done)
        begin
            checked++;
            if (pending_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status=%0d plus=%0d minus=%0d",
                             status, root_plus, root_minus);
            end
            else
            begin
                want = pending_roots.pop_front();
                st_seen[want.st]++;
                if (status !== want.st || root_plus !== want.rp || root_minus !== want.rm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: status %0d/%0d plus %0d/%0d minus %0d/%0d",
                                 want.st, status, want.rp, root_plus, want.rm, root_minus);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        // directed rows; expected values typed where obvious
        add_row(0, 5, 7, 1, ST_A_ZERO, 0, 0);
        add_row(0, -32768, -32768, 1, ST_A_ZERO, 0, 0);
        add_row(0, 0, 0, 1, ST_A_ZERO, 0, 0);
        add_row(1, 2, 1, 1, ST_D_ZERO, 0, 0);
        add_row(-3, 0, 0, 1, ST_D_ZERO, 0, 0);
        add_row(1, 0, 1, 1, ST_D_NEG, 0, 0);
        add_row(32767, 0, 32767, 1, ST_D_NEG, 0, 0);
        add_row(-32768, 1, -32768, 1, ST_D_NEG, 0, 0);
        add_row(1, -3, 2, 1, ST_OK, 2 * 65536, 65536);
        add_row(-1, 3, -2, 1, ST_OK, 65536, 2 * 65536);
        add_row(1, 0, -1, 1, ST_OK, 65536, -65536);
        add_row(-32768, -32768, 32767, 0, ST_OK, 0, 0);
        add_row(-32768, 32767, 32767, 0, ST_OK, 0, 0);
        add_row(32767, -32768, -32768, 0, ST_OK, 0, 0);
        add_row(1, -32768, -32768, 0, ST_OK, 0, 0);
        add_row(-1, 32767, 32767, 0, ST_OK, 0, 0);
        add_row(1, 32767, 0, 0, ST_OK, 0, 0);
        add_row(-32768, 0, 32767, 0, ST_OK, 0, 0);
        add_row(32767, 32767, -1, 0, ST_OK, 0, 0);
        add_row(2, 3, -5, 0, ST_OK, 0, 0);
        add_row(3, 1, -1, 0, ST_OK, 0, 0);
        add_row(1, -32768, 32767, 0, ST_OK, 0, 0);

        repeat (5) @(posedge clk);
        rst_n <= 1;

        foreach (directed[i])
            send_coefs(directed[i].a, directed[i].b, directed[i].c,
                       directed[i].typed, directed[i].res);

        for (int n = 0; n < RANDOM_SETS; n++)
        begin
            // hold off once until everything in flight has drained
            if (n == RANDOM_SETS / 2)
            begin
                start <= 0;
                @(posedge clk);
                while (pending_roots.size() != 0)
                    @(posedge clk);
            end
            send_random();
        end
        start <= 0;

        while (pending_roots.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);

        $display("checked %0d root sets: ok %0d, a zero %0d, repeated root %0d, complex %0d",
                 checked, st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
        $display("%0d mismatches over %0d cycles", mismatches, cycles);
        if (mismatches == 0 && pending_roots.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/qrs_pkg.sv
design/quadratic_root_solver.sv
design/qrs_checker.sv
test/quadratic_root_solver_test.sv
